### hw/rtl/rtv_pkg.sv
// Shared constants, reason codes and the azimuth wrap helper for the
// rotator target validator. No dependencies.
package rtv_pkg;

  localparam int ANGLE_BITS  = 21;
  localparam int TIME_BITS   = 32;
  localparam int ELEV_BITS   = 20;
  localparam int REASON_BITS = 3;
  localparam int CFG_IDX_BITS = 3;
  // working width for angles: holds sums up to three half turns past the limit
  localparam int NORM_BITS   = (ANGLE_BITS > 22) ? ANGLE_BITS + 2 : 24;

  typedef logic signed [NORM_BITS-1:0] angle_t;
  typedef logic [REASON_BITS-1:0]      reason_t;
  typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;

  localparam reason_t RSN_OK        = 3'd0;
  localparam reason_t RSN_AZ_ABS    = 3'd1;
  localparam reason_t RSN_EL_ABS    = 3'd2;
  localparam reason_t RSN_WRAP      = 3'd3;
  localparam reason_t RSN_AZ_RANGE  = 3'd4;
  localparam reason_t RSN_EL_LOW    = 3'd5;
  localparam reason_t RSN_EL_HIGH   = 3'd6;

  localparam cfg_idx_t CFG_AZ_MIN   = 3'd0;
  localparam cfg_idx_t CFG_AZ_MAX   = 3'd1;
  localparam cfg_idx_t CFG_EL_MIN   = 3'd2;
  localparam cfg_idx_t CFG_EL_MAX   = 3'd3;
  localparam cfg_idx_t CFG_WRAP     = 3'd4;
  localparam cfg_idx_t CFG_WIN_START = 3'd5;
  localparam cfg_idx_t CFG_WIN_END  = 3'd6;

  localparam angle_t AZ_ABS_HI     = angle_t'(720000);
  localparam angle_t AZ_ABS_LO     = angle_t'(-720000);
  localparam angle_t EL_ABS_HI     = angle_t'(270000);
  localparam angle_t EL_ABS_LO     = angle_t'(-90000);
  localparam angle_t FULL_TURN     = angle_t'(360000);
  localparam angle_t NEG_FULL_TURN = angle_t'(-360000);
  localparam angle_t TWO_TURNS     = angle_t'(720000);
  localparam angle_t HALF_TURN     = angle_t'(180000);
  localparam angle_t NEG_HALF_TURN = angle_t'(-180000);

  localparam logic [ANGLE_BITS-1:0] AZ_MIN_RST = ANGLE_BITS'(0);
  localparam logic [ANGLE_BITS-1:0] AZ_MAX_RST = ANGLE_BITS'(360000);
  localparam logic [ELEV_BITS-1:0]  EL_MIN_RST = ELEV_BITS'(0);
  localparam logic [ELEV_BITS-1:0]  EL_MAX_RST = ELEV_BITS'(90000);

  // Reduce x into [0, 360000); valid for x in [-720000, 1080000).
  function automatic angle_t wrap_turn(input angle_t x);
    angle_t r;
    if (x >= TWO_TURNS) begin
      r = x - TWO_TURNS;
    end else if (x >= FULL_TURN) begin
      r = x - FULL_TURN;
    end else if (x >= angle_t'(0)) begin
      r = x;
    end else if (x >= NEG_FULL_TURN) begin
      r = x + FULL_TURN;
    end else begin
      r = x + TWO_TURNS;
    end
    return r;
  endfunction

endpackage

### hw/rtl/rotator_target_validator.sv
// Rotator target validator top level: input register, check logic, result
// register and search state. Depends on rtv_pkg.
//
// Usage:
//   Samples enter on the in_ channel (valid/ready); each gives exactly one
//   result on the out_ channel. Limits and the search window are written on
//   the cfg_ channel (index + data), which is always ready; write it only
//   while no request is in flight.
//   A request passes through two register stages (input register, result
//   register) before its result shows on out_.
//   Throughput: one request per cycle while out_ready is high; all checks
//   are adds and compares in one pass between the two registers.
//   Stall: when out_ready is low the result holds; the input register still
//   takes one more request, after which in_ready drops until the result
//   register drains.
//   Reset (rst_n low, synchronous): both stages empty, registers back to
//   their defaults (az 0..360 deg, el 0..90 deg, 0..360 mode, full window),
//   search state cleared. A request with last_sample set closes the search
//   and clears found/fail state after its result is formed.
module rotator_target_validator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rtv_pkg::TIME_BITS-1:0]      in_sample_time,
  input  logic signed [rtv_pkg::ANGLE_BITS-1:0] in_az_millideg,
  input  logic signed [rtv_pkg::ANGLE_BITS-1:0] in_el_millideg,
  input  logic                               in_last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_target_ok,
  output logic [rtv_pkg::REASON_BITS-1:0]    out_reason,
  output logic signed [rtv_pkg::ANGLE_BITS-1:0] out_az_normalized,
  output logic                               out_in_window,
  output logic                               out_first_hit,
  output logic                               out_search_done,
  output logic                               out_search_found,
  output logic [rtv_pkg::REASON_BITS-1:0]    out_final_reason,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rtv_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rtv_pkg::TIME_BITS-1:0]      cfg_data
);

  localparam int AB = rtv_pkg::ANGLE_BITS;
  localparam int EB = rtv_pkg::ELEV_BITS;
  localparam int NB = rtv_pkg::NORM_BITS;

  // configuration registers
  logic signed [AB-1:0]        az_min_r, az_max_r;
  logic signed [EB-1:0]        el_min_r, el_max_r;
  logic                        wrap_sel_r;
  logic [rtv_pkg::TIME_BITS-1:0] win_start_r, win_end_r;

  // input stage
  logic                        s1_valid_r;
  logic [rtv_pkg::TIME_BITS-1:0] s1_time_r;
  logic signed [AB-1:0]        s1_az_r, s1_el_r;
  logic                        s1_last_r;

  // result stage
  logic                        out_valid_r;
  logic                        ok_r, inwin_r, hit_r, done_r, found_out_r;
  rtv_pkg::reason_t            reason_r, final_reason_r;
  logic signed [AB-1:0]        az_norm_r;

  // search state
  logic                        found_flag_r, found_flag_nxt;
  rtv_pkg::reason_t            last_fail_r, last_fail_nxt;

  logic                        advance;
  logic                        in_accept;

  rtv_pkg::angle_t             az_x, el_x, az_min_x, az_max_x, el_min_x, el_max_x;
  rtv_pkg::angle_t             span, norm, az_rep;
  rtv_pkg::reason_t            reason_c;
  logic                        ok_c, inwin_c, hit_c;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_min_r    <= rtv_pkg::AZ_MIN_RST;
      az_max_r    <= rtv_pkg::AZ_MAX_RST;
      el_min_r    <= rtv_pkg::EL_MIN_RST;
      el_max_r    <= rtv_pkg::EL_MAX_RST;
      wrap_sel_r  <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtv_pkg::CFG_AZ_MIN:    az_min_r    <= cfg_data[AB-1:0];
        rtv_pkg::CFG_AZ_MAX:    az_max_r    <= cfg_data[AB-1:0];
        rtv_pkg::CFG_EL_MIN:    el_min_r    <= cfg_data[EB-1:0];
        rtv_pkg::CFG_EL_MAX:    el_max_r    <= cfg_data[EB-1:0];
        rtv_pkg::CFG_WRAP:      wrap_sel_r  <= cfg_data[0];
        rtv_pkg::CFG_WIN_START: win_start_r <= cfg_data;
        rtv_pkg::CFG_WIN_END:   win_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_time_r <= in_sample_time;
      s1_az_r   <= in_az_millideg;
      s1_el_r   <= in_el_millideg;
      s1_last_r <= in_last_sample;
    end
  end

  // sign-extend everything to the working width
  always_comb begin
    az_x     = {{(NB-AB){s1_az_r[AB-1]}}, s1_az_r};
    el_x     = {{(NB-AB){s1_el_r[AB-1]}}, s1_el_r};
    az_min_x = {{(NB-AB){az_min_r[AB-1]}}, az_min_r};
    az_max_x = {{(NB-AB){az_max_r[AB-1]}}, az_max_r};
    el_min_x = {{(NB-EB){el_min_r[EB-1]}}, el_min_r};
    el_max_x = {{(NB-EB){el_max_r[EB-1]}}, el_max_r};
    span     = az_max_x - az_min_x;
  end

  always_comb begin
    az_rep = az_x;
    norm   = az_x;
    if (wrap_sel_r) begin
      norm = rtv_pkg::wrap_turn(az_x + rtv_pkg::HALF_TURN) - rtv_pkg::HALF_TURN;
    end else if (span <= rtv_pkg::FULL_TURN) begin
      norm = rtv_pkg::wrap_turn(az_x);
    end

    if (az_x < rtv_pkg::AZ_ABS_LO || az_x > rtv_pkg::AZ_ABS_HI) begin
      reason_c = rtv_pkg::RSN_AZ_ABS;
    end else if (el_x < rtv_pkg::EL_ABS_LO || el_x > rtv_pkg::EL_ABS_HI) begin
      reason_c = rtv_pkg::RSN_EL_ABS;
    end else if (wrap_sel_r &&
                 (az_min_x < rtv_pkg::NEG_HALF_TURN || az_max_x > rtv_pkg::HALF_TURN)) begin
      reason_c = rtv_pkg::RSN_WRAP;
    end else begin
      az_rep = norm;
      // min > max is a window that wraps round
      if ((az_min_x <= az_max_x) ? (norm < az_min_x || norm > az_max_x)
                                 : (norm < az_min_x && norm > az_max_x)) begin
        reason_c = rtv_pkg::RSN_AZ_RANGE;
      end else if (el_x < el_min_x) begin
        reason_c = rtv_pkg::RSN_EL_LOW;
      end else if (el_x > el_max_x) begin
        reason_c = rtv_pkg::RSN_EL_HIGH;
      end else begin
        reason_c = rtv_pkg::RSN_OK;
      end
    end
  end

  assign ok_c    = (reason_c == rtv_pkg::RSN_OK);
  assign inwin_c = (s1_time_r >= win_start_r) && (s1_time_r <= win_end_r);
  assign hit_c   = inwin_c && !found_flag_r && ok_c;

  always_comb begin
    found_flag_nxt = found_flag_r;
    last_fail_nxt  = last_fail_r;
    if (inwin_c && !found_flag_r) begin
      if (ok_c) begin
        found_flag_nxt = 1'b1;
      end else begin
        last_fail_nxt = reason_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_flag_r <= 1'b0;
      last_fail_r  <= rtv_pkg::RSN_OK;
    end else if (advance) begin
      found_flag_r <= s1_last_r ? 1'b0 : found_flag_nxt;
      last_fail_r  <= s1_last_r ? rtv_pkg::RSN_OK : last_fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok_r           <= ok_c;
      reason_r       <= reason_c;
      az_norm_r      <= az_rep[AB-1:0];
      inwin_r        <= inwin_c;
      hit_r          <= hit_c;
      done_r         <= s1_last_r;
      found_out_r    <= s1_last_r && found_flag_nxt;
      final_reason_r <= (s1_last_r && !found_flag_nxt) ? last_fail_nxt : rtv_pkg::RSN_OK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target_ok     = ok_r;
  assign out_reason        = reason_r;
  assign out_az_normalized = az_norm_r;
  assign out_in_window     = inwin_r;
  assign out_first_hit     = hit_r;
  assign out_search_done   = done_r;
  assign out_search_found  = found_out_r;
  assign out_final_reason  = final_reason_r;

  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> ok_r && inwin_r)
    else $error("first hit on a failing or out-of-window sample");

  a_found_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (found_out_r || final_reason_r != rtv_pkg::RSN_OK) |-> done_r)
    else $error("search outcome reported before the last sample");

  a_found_excludes_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_out_r |-> final_reason_r == rtv_pkg::RSN_OK)
    else $error("final reason set on a successful search");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> !found_flag_r && last_fail_r == rtv_pkg::RSN_OK)
    else $error("search state not cleared after last sample");

  a_hit_needs_empty_search: assert property (@(posedge clk) disable iff (!rst_n)
    advance && found_flag_r |=> !hit_r)
    else $error("second hit in one search");

endmodule
